// ===== hdl/sbcu_pkg.sv =====
// Package for the single-byte charset to UTF-8 unit: charset codes, queue entry
// type, code-point ROMs and the UTF-8 encoder function. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package sbcu_pkg;

    typedef enum logic [2:0] {
        CS_PASS   = 3'd0,
        CS_LATIN1 = 3'd1,
        CS_ISO2   = 3'd2,
        CS_W1250  = 3'd3,
        CS_W1252  = 3'd4,
        CS_CP852  = 3'd5
    } charset_t;

    localparam int  CFG_ADDR_W             = 3;
    localparam int  CFG_DATA_W             = 32;
    localparam logic CFG_IDX_SOURCE_CHARSET = 1'b0;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [1:0] len;
    } utf8_run_t;

    typedef struct packed {
        logic      valid;
        utf8_run_t run;
    } q_head_t;

    localparam logic [15:0] ROM_ISO2 [128] = '{
        16'h0080,16'h0081,16'h0082,16'h0083,16'h0084,16'h0085,16'h0086,16'h0087,
        16'h0088,16'h0089,16'h008A,16'h008B,16'h008C,16'h008D,16'h008E,16'h008F,
        16'h0090,16'h0091,16'h0092,16'h0093,16'h0094,16'h0095,16'h0096,16'h0097,
        16'h0098,16'h0099,16'h009A,16'h009B,16'h009C,16'h009D,16'h009E,16'h009F,
        16'h00A0,16'h0104,16'h02D8,16'h0141,16'h00A4,16'h013D,16'h015A,16'h00A7,
        16'h00A8,16'h0160,16'h015E,16'h0164,16'h0179,16'h00AD,16'h017D,16'h017B,
        16'h00B0,16'h0105,16'h02DB,16'h0142,16'h00B4,16'h013E,16'h015B,16'h02C7,
        16'h00B8,16'h0161,16'h015F,16'h0165,16'h017A,16'h02DD,16'h017E,16'h017C,
        16'h0154,16'h00C1,16'h00C2,16'h0102,16'h00C4,16'h0139,16'h0106,16'h00C7,
        16'h010C,16'h00C9,16'h0118,16'h00CB,16'h011A,16'h00CD,16'h00CE,16'h010E,
        16'h0110,16'h0143,16'h0147,16'h00D3,16'h00D4,16'h0150,16'h00D6,16'h00D7,
        16'h0158,16'h016E,16'h00DA,16'h0170,16'h00DC,16'h00DD,16'h0162,16'h00DF,
        16'h0155,16'h00E1,16'h00E2,16'h0103,16'h00E4,16'h013A,16'h0107,16'h00E7,
        16'h010D,16'h00E9,16'h0119,16'h00EB,16'h011B,16'h00ED,16'h00EE,16'h010F,
        16'h0111,16'h0144,16'h0148,16'h00F3,16'h00F4,16'h0151,16'h00F6,16'h00F7,
        16'h0159,16'h016F,16'h00FA,16'h0171,16'h00FC,16'h00FD,16'h0163,16'h02D9
    };

    localparam logic [15:0] ROM_W1250 [128] = '{
        16'h20AC,16'hFFFD,16'h201A,16'hFFFD,16'h201E,16'h2026,16'h2020,16'h2021,
        16'hFFFD,16'h2030,16'h0160,16'h2039,16'h015A,16'h0164,16'h017D,16'h0179,
        16'hFFFD,16'h2018,16'h2019,16'h201C,16'h201D,16'h2022,16'h2013,16'h2014,
        16'hFFFD,16'h2122,16'h0161,16'h203A,16'h015B,16'h0165,16'h017E,16'h017A,
        16'h00A0,16'h02C7,16'h02D8,16'h0141,16'h00A4,16'h0104,16'h00A6,16'h00A7,
        16'h00A8,16'h00A9,16'h015E,16'h00AB,16'h00AC,16'h00AD,16'h00AE,16'h017B,
        16'h00B0,16'h00B1,16'h02DB,16'h0142,16'h00B4,16'h00B5,16'h00B6,16'h00B7,
        16'h00B8,16'h0105,16'h015F,16'h00BB,16'h013D,16'h02DD,16'h013E,16'h017C,
        16'h0154,16'h00C1,16'h00C2,16'h0102,16'h00C4,16'h0139,16'h0106,16'h00C7,
        16'h010C,16'h00C9,16'h0118,16'h00CB,16'h011A,16'h00CD,16'h00CE,16'h010E,
        16'h0110,16'h0143,16'h0147,16'h00D3,16'h00D4,16'h0150,16'h00D6,16'h00D7,
        16'h0158,16'h016E,16'h00DA,16'h0170,16'h00DC,16'h00DD,16'h0162,16'h00DF,
        16'h0155,16'h00E1,16'h00E2,16'h0103,16'h00E4,16'h013A,16'h0107,16'h00E7,
        16'h010D,16'h00E9,16'h0119,16'h00EB,16'h011B,16'h00ED,16'h00EE,16'h010F,
        16'h0111,16'h0144,16'h0148,16'h00F3,16'h00F4,16'h0151,16'h00F6,16'h00F7,
        16'h0159,16'h016F,16'h00FA,16'h0171,16'h00FC,16'h00FD,16'h0163,16'h02D9
    };

    localparam logic [15:0] ROM_W1252 [128] = '{
        16'h20AC,16'hFFFD,16'h201A,16'h0192,16'h201E,16'h2026,16'h2020,16'h2021,
        16'h02C6,16'h2030,16'h0160,16'h2039,16'h0152,16'hFFFD,16'h017D,16'hFFFD,
        16'hFFFD,16'h2018,16'h2019,16'h201C,16'h201D,16'h2022,16'h2013,16'h2014,
        16'h02DC,16'h2122,16'h0161,16'h203A,16'h0153,16'hFFFD,16'h017E,16'h0178,
        16'h00A0,16'h00A1,16'h00A2,16'h00A3,16'h00A4,16'h00A5,16'h00A6,16'h00A7,
        16'h00A8,16'h00A9,16'h00AA,16'h00AB,16'h00AC,16'h00AD,16'h00AE,16'h00AF,
        16'h00B0,16'h00B1,16'h00B2,16'h00B3,16'h00B4,16'h00B5,16'h00B6,16'h00B7,
        16'h00B8,16'h00B9,16'h00BA,16'h00BB,16'h00BC,16'h00BD,16'h00BE,16'h00BF,
        16'h00C0,16'h00C1,16'h00C2,16'h00C3,16'h00C4,16'h00C5,16'h00C6,16'h00C7,
        16'h00C8,16'h00C9,16'h00CA,16'h00CB,16'h00CC,16'h00CD,16'h00CE,16'h00CF,
        16'h00D0,16'h00D1,16'h00D2,16'h00D3,16'h00D4,16'h00D5,16'h00D6,16'h00D7,
        16'h00D8,16'h00D9,16'h00DA,16'h00DB,16'h00DC,16'h00DD,16'h00DE,16'h00DF,
        16'h00E0,16'h00E1,16'h00E2,16'h00E3,16'h00E4,16'h00E5,16'h00E6,16'h00E7,
        16'h00E8,16'h00E9,16'h00EA,16'h00EB,16'h00EC,16'h00ED,16'h00EE,16'h00EF,
        16'h00F0,16'h00F1,16'h00F2,16'h00F3,16'h00F4,16'h00F5,16'h00F6,16'h00F7,
        16'h00F8,16'h00F9,16'h00FA,16'h00FB,16'h00FC,16'h00FD,16'h00FE,16'h00FF
    };

    localparam logic [15:0] ROM_CP852 [128] = '{
        16'h00C7,16'h00FC,16'h00E9,16'h00E2,16'h00E4,16'h016F,16'h0107,16'h00E7,
        16'h0142,16'h00EB,16'h0150,16'h0151,16'h00EE,16'h0179,16'h00C4,16'h0106,
        16'h00C9,16'h0139,16'h013A,16'h00F4,16'h00F6,16'h013D,16'h013E,16'h015A,
        16'h015B,16'h00D6,16'h00DC,16'h0164,16'h0165,16'h0141,16'h00D7,16'h010D,
        16'h00E1,16'h00ED,16'h00F3,16'h00FA,16'h0104,16'h0105,16'h017D,16'h017E,
        16'h0118,16'h0119,16'h00AC,16'h017A,16'h010C,16'h015F,16'h00AB,16'h00BB,
        16'h2591,16'h2592,16'h2593,16'h2502,16'h2524,16'h00C1,16'h00C2,16'h011A,
        16'h015E,16'h2563,16'h2551,16'h2557,16'h255D,16'h017B,16'h017C,16'h2510,
        16'h2514,16'h2534,16'h252C,16'h251C,16'h2500,16'h253C,16'h0102,16'h0103,
        16'h255A,16'h2554,16'h2569,16'h2566,16'h2560,16'h2550,16'h256C,16'h00A4,
        16'h0111,16'h0110,16'h010E,16'h00CB,16'h010F,16'h0147,16'h00CD,16'h00CE,
        16'h011B,16'h2518,16'h250C,16'h2588,16'h2584,16'h0162,16'h016E,16'h2580,
        16'h00D3,16'h00DF,16'h00D4,16'h0143,16'h0144,16'h0148,16'h0160,16'h0161,
        16'h0154,16'h00DA,16'h0155,16'h0170,16'h00FD,16'h00DD,16'h0163,16'h00B4,
        16'h00AD,16'h02DD,16'h02DB,16'h02C7,16'h02D8,16'h00A7,16'h00F7,16'h00B8,
        16'h00B0,16'h00A8,16'h02D9,16'h0171,16'h0158,16'h0159,16'h25A0,16'h00A0
    };

    function automatic utf8_run_t utf8_encode(input logic [15:0] cp);
        utf8_run_t r;
        r = '0;
        if (cp < 16'h0080) begin
            r.b0  = cp[7:0];
            r.len = 2'd1;
        end
        else if (cp < 16'h0800) begin
            r.b0  = 8'hC0 | {3'b000, cp[10:6]};
            r.b1  = 8'h80 | {2'b00, cp[5:0]};
            r.len = 2'd2;
        end
        else begin
            r.b0  = 8'hE0 | {4'b0000, cp[15:12]};
            r.b1  = 8'h80 | {2'b00, cp[11:6]};
            r.b2  = 8'h80 | {2'b00, cp[5:0]};
            r.len = 2'd3;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/sbcu_front.sv =====
// Front end: accepts text bytes, maps them to code points and encodes the UTF-8 run.
// Depends on sbcu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbcu_front
    import sbcu_pkg::*;
(
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] text_byte,
    input  wire charset_t   charset,
    input  wire logic       q_full,
    output logic            q_push,
    output utf8_run_t       q_wdata
);

    logic [15:0] cp;
    logic [6:0]  idx;

    assign idx      = text_byte[6:0];
    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        cp = {8'h00, text_byte};
        if (text_byte[7]) begin
            case (charset)
                CS_ISO2:  cp = ROM_ISO2[idx];
                CS_W1250: cp = ROM_W1250[idx];
                CS_W1252: cp = ROM_W1252[idx];
                CS_CP852: cp = ROM_CP852[idx];
                default:  cp = {8'h00, text_byte};
            endcase
        end
    end

    always_comb
    begin
        if (charset == CS_PASS) begin
            q_wdata     = '0;
            q_wdata.b0  = text_byte;
            q_wdata.len = 2'd1;
        end
        else begin
            q_wdata = utf8_encode(cp);
        end
    end

endmodule

`default_nettype wire

// ===== hdl/sbcu_queue.sv =====
// Short queue of encoded runs between the front end and the byte serialiser.
// Depends on sbcu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbcu_queue
    import sbcu_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire utf8_run_t wdata,
    output logic           full,
    input  wire logic      pop,
    output q_head_t        head
);

    utf8_run_t          mem_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  cnt_reg, cnt_next;
    logic               do_push, do_pop;

    assign full       = (cnt_reg == QCNT_W'(QDEPTH));
    assign head.valid = (cnt_reg != '0);
    assign head.run   = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/sbcu_back.sv =====
// Back end: serialises each queued run into UTF-8 beats, one byte per cycle while out_stall is low,
// through an output register. Depends on sbcu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbcu_back
    import sbcu_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire q_head_t head,
    output logic         pop,
    output logic         out_valid,
    input  wire logic    out_stall,
    output logic [7:0]   utf8_byte,
    output logic         run_last
);

    logic        out_valid_reg, out_valid_next;
    logic [7:0]  byte_reg, byte_next;
    logic        last_reg, last_next;
    logic [15:0] pend_reg, pend_next;
    logic [1:0]  pend_cnt_reg, pend_cnt_next;
    logic        load;

    assign load      = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign utf8_byte = byte_reg;
    assign run_last  = last_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        pend_next      = pend_reg;
        pend_cnt_next  = pend_cnt_reg;
        pop            = 1'b0;
        if (load) begin
            // drain the rest of the current run before taking the next one
            if (pend_cnt_reg != 2'd0) begin
                out_valid_next = 1'b1;
                byte_next      = pend_reg[15:8];
                last_next      = (pend_cnt_reg == 2'd1);
                pend_next      = {pend_reg[7:0], 8'h00};
                pend_cnt_next  = pend_cnt_reg - 2'd1;
            end
            else if (head.valid) begin
                pop            = 1'b1;
                out_valid_next = 1'b1;
                byte_next      = head.run.b0;
                last_next      = (head.run.len == 2'd1);
                pend_next      = {head.run.b1, head.run.b2};
                pend_cnt_next  = head.run.len - 2'd1;
            end
            else begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
            pend_cnt_reg  <= 2'd0;
        end
        else begin
            out_valid_reg <= out_valid_next;
            pend_cnt_reg  <= pend_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        last_reg <= last_next;
        pend_reg <= pend_next;
    end

endmodule

`default_nettype wire

// ===== hdl/single_byte_charset_to_utf8_unit.sv =====
// Single-byte charset to UTF-8 unit: top level with the configuration port.
// Depends on sbcu_pkg, sbcu_front, sbcu_queue and sbcu_back.
// The first beat of a run passes through the run queue and then the output register before it is shown.
// Throughput: one output beat per cycle while out_stall is low, so a byte yields 1, 2 or 3 beats (its UTF-8 length);
// the four-entry run queue lets input be taken while output stalls.
// Reset: rst_n clears the queue, the output stage and sets source_charset to passthrough.
`timescale 1ns / 1ps
`default_nettype none

module single_byte_charset_to_utf8_unit
    import sbcu_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [7:0]            text_byte,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [7:0]                 utf8_byte,
    output logic                       run_last
);

    charset_t  source_charset_reg, source_charset_next;
    logic      cfg_wr;
    logic      q_full;
    logic      q_push;
    logic      q_pop;
    utf8_run_t q_wdata;
    q_head_t   q_head;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == CFG_IDX_SOURCE_CHARSET);

    always_comb
    begin
        source_charset_next = source_charset_reg;
        if (cfg_wr) begin
            source_charset_next = charset_t'(pwdata[2:0]);
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == CFG_IDX_SOURCE_CHARSET) begin
            prdata = {{(CFG_DATA_W-3){1'b0}}, source_charset_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            source_charset_reg <= CS_PASS;
        end
        else begin
            source_charset_reg <= source_charset_next;
        end
    end

    sbcu_front u_front (
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .text_byte (text_byte),
        .charset   (source_charset_reg),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_wdata   (q_wdata)
    );

    sbcu_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .head  (q_head)
    );

    sbcu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .utf8_byte (utf8_byte),
        .run_last  (run_last)
    );

endmodule

`default_nettype wire

// ===== bench/tb_single_byte_charset_to_utf8_unit.sv =====
// Testbench for single_byte_charset_to_utf8_unit: drives text bytes under every charset
// setting and checks each UTF-8 beat against an in-bench transcoder with its own code tables.
// Depends on sbcu_pkg and the unit's RTL.
`timescale 1ns / 1ps

module tb_single_byte_charset_to_utf8_unit;
    import sbcu_pkg::*;

    localparam logic [2:0] CS_SPARE_6 = 3'd6;
    localparam logic [2:0] CS_SPARE_7 = 3'd7;
    localparam logic [CFG_ADDR_W-1:0] CHARSET_ADDR = CFG_ADDR_W'(4 * CFG_IDX_SOURCE_CHARSET);
    localparam int ITEMS_PER_PHASE = 27;
    localparam logic [2:0] PHASE_CHARSETS [9] = '{CS_CP852, CS_PASS, CS_ISO2, CS_W1252,
        CS_LATIN1, CS_W1250, CS_SPARE_7, CS_SPARE_6, CS_CP852};

    // Windows-1252, 0x80..0x9F; the rest of the upper half is identity
    localparam logic [15:0] W1252_LOW [32] = '{
        16'h20AC, 16'hFFFD, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
        16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'hFFFD, 16'h017D, 16'hFFFD,
        16'hFFFD, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
        16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'hFFFD, 16'h017E, 16'h0178
    };

    // ISO-8859-2, 0xA0..0xBF; 0x80..0x9F is identity
    localparam logic [15:0] ISO2_A0 [32] = '{
        16'h00A0, 16'h0104, 16'h02D8, 16'h0141, 16'h00A4, 16'h013D, 16'h015A, 16'h00A7,
        16'h00A8, 16'h0160, 16'h015E, 16'h0164, 16'h0179, 16'h00AD, 16'h017D, 16'h017B,
        16'h00B0, 16'h0105, 16'h02DB, 16'h0142, 16'h00B4, 16'h013E, 16'h015B, 16'h02C7,
        16'h00B8, 16'h0161, 16'h015F, 16'h0165, 16'h017A, 16'h02DD, 16'h017E, 16'h017C
    };

    // Windows-1250, 0x80..0xBF
    localparam logic [15:0] W1250_LOW [64] = '{
        16'h20AC, 16'hFFFD, 16'h201A, 16'hFFFD, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
        16'hFFFD, 16'h2030, 16'h0160, 16'h2039, 16'h015A, 16'h0164, 16'h017D, 16'h0179,
        16'hFFFD, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
        16'hFFFD, 16'h2122, 16'h0161, 16'h203A, 16'h015B, 16'h0165, 16'h017E, 16'h017A,
        16'h00A0, 16'h02C7, 16'h02D8, 16'h0141, 16'h00A4, 16'h0104, 16'h00A6, 16'h00A7,
        16'h00A8, 16'h00A9, 16'h015E, 16'h00AB, 16'h00AC, 16'h00AD, 16'h00AE, 16'h017B,
        16'h00B0, 16'h00B1, 16'h02DB, 16'h0142, 16'h00B4, 16'h00B5, 16'h00B6, 16'h00B7,
        16'h00B8, 16'h0105, 16'h015F, 16'h00BB, 16'h013D, 16'h02DD, 16'h013E, 16'h017C
    };

    // 0xC0..0xFF, common to ISO-8859-2 and Windows-1250
    localparam logic [15:0] EAST_HIGH [64] = '{
        16'h0154, 16'h00C1, 16'h00C2, 16'h0102, 16'h00C4, 16'h0139, 16'h0106, 16'h00C7,
        16'h010C, 16'h00C9, 16'h0118, 16'h00CB, 16'h011A, 16'h00CD, 16'h00CE, 16'h010E,
        16'h0110, 16'h0143, 16'h0147, 16'h00D3, 16'h00D4, 16'h0150, 16'h00D6, 16'h00D7,
        16'h0158, 16'h016E, 16'h00DA, 16'h0170, 16'h00DC, 16'h00DD, 16'h0162, 16'h00DF,
        16'h0155, 16'h00E1, 16'h00E2, 16'h0103, 16'h00E4, 16'h013A, 16'h0107, 16'h00E7,
        16'h010D, 16'h00E9, 16'h0119, 16'h00EB, 16'h011B, 16'h00ED, 16'h00EE, 16'h010F,
        16'h0111, 16'h0144, 16'h0148, 16'h00F3, 16'h00F4, 16'h0151, 16'h00F6, 16'h00F7,
        16'h0159, 16'h016F, 16'h00FA, 16'h0171, 16'h00FC, 16'h00FD, 16'h0163, 16'h02D9
    };

    localparam logic [15:0] CP852_HIGH [128] = '{
        16'h00C7, 16'h00FC, 16'h00E9, 16'h00E2, 16'h00E4, 16'h016F, 16'h0107, 16'h00E7,
        16'h0142, 16'h00EB, 16'h0150, 16'h0151, 16'h00EE, 16'h0179, 16'h00C4, 16'h0106,
        16'h00C9, 16'h0139, 16'h013A, 16'h00F4, 16'h00F6, 16'h013D, 16'h013E, 16'h015A,
        16'h015B, 16'h00D6, 16'h00DC, 16'h0164, 16'h0165, 16'h0141, 16'h00D7, 16'h010D,
        16'h00E1, 16'h00ED, 16'h00F3, 16'h00FA, 16'h0104, 16'h0105, 16'h017D, 16'h017E,
        16'h0118, 16'h0119, 16'h00AC, 16'h017A, 16'h010C, 16'h015F, 16'h00AB, 16'h00BB,
        16'h2591, 16'h2592, 16'h2593, 16'h2502, 16'h2524, 16'h00C1, 16'h00C2, 16'h011A,
        16'h015E, 16'h2563, 16'h2551, 16'h2557, 16'h255D, 16'h017B, 16'h017C, 16'h2510,
        16'h2514, 16'h2534, 16'h252C, 16'h251C, 16'h2500, 16'h253C, 16'h0102, 16'h0103,
        16'h255A, 16'h2554, 16'h2569, 16'h2566, 16'h2560, 16'h2550, 16'h256C, 16'h00A4,
        16'h0111, 16'h0110, 16'h010E, 16'h00CB, 16'h010F, 16'h0147, 16'h00CD, 16'h00CE,
        16'h011B, 16'h2518, 16'h250C, 16'h2588, 16'h2584, 16'h0162, 16'h016E, 16'h2580,
        16'h00D3, 16'h00DF, 16'h00D4, 16'h0143, 16'h0144, 16'h0148, 16'h0160, 16'h0161,
        16'h0154, 16'h00DA, 16'h0155, 16'h0170, 16'h00FD, 16'h00DD, 16'h0163, 16'h00B4,
        16'h00AD, 16'h02DD, 16'h02DB, 16'h02C7, 16'h02D8, 16'h00A7, 16'h00F7, 16'h00B8,
        16'h00B0, 16'h00A8, 16'h02D9, 16'h0171, 16'h0158, 16'h0159, 16'h25A0, 16'h00A0
    };

    typedef struct {
        logic [7:0] octet;
        logic       last;
    } utf8_beat_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [7:0]            text_byte = 8'h00;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [7:0]            utf8_byte;
    logic                  run_last;

    logic [7:0] text_q [$];
    utf8_beat_t utf8_exp_q [$];
    logic [2:0] src_mode = CS_PASS;
    int         send_idle_pct = 15;
    int         recv_stall_pct = 15;
    int         mismatches = 0;
    int         bytes_sent = 0;
    int         beats_checked = 0;
    int         settings_used = 0;
    int         runs_by_len [1:3] = '{0, 0, 0};

    single_byte_charset_to_utf8_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .text_byte (text_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .utf8_byte (utf8_byte),
        .run_last  (run_last)
    );

    always #5 clk = ~clk;

    function automatic logic [15:0] code_point(input logic [2:0] cs, input logic [7:0] b);
        logic [6:0] idx;
        idx = b[6:0];
        if (!b[7])
            return {8'h00, b};
        case (cs)
            CS_ISO2:
                return !idx[6] ? (idx[5] ? ISO2_A0[idx[4:0]] : {8'h00, b}) : EAST_HIGH[idx[5:0]];
            CS_W1250:
                return idx[6] ? EAST_HIGH[idx[5:0]] : W1250_LOW[idx[5:0]];
            CS_W1252:
                return (idx < 7'h20) ? W1252_LOW[idx[4:0]] : {8'h00, b};
            CS_CP852:
                return CP852_HIGH[idx];
            default:
                return {8'h00, b};
        endcase
    endfunction

    function automatic void expect_beat(input logic [7:0] octet, input logic last);
        utf8_exp_q.push_back('{octet, last});
    endfunction

    function automatic void predict_run(input logic [7:0] b);
        logic [15:0] cp;
        cp = (src_mode == CS_PASS) ? {8'h00, 8'h00} : code_point(src_mode, b);
        if (src_mode == CS_PASS) begin
            expect_beat(b, 1'b1);
            runs_by_len[1]++;
        end
        else if (cp < 16'h0080) begin
            expect_beat(cp[7:0], 1'b1);
            runs_by_len[1]++;
        end
        else if (cp < 16'h0800) begin
            expect_beat({3'b110, cp[10:6]}, 1'b0);
            expect_beat({2'b10, cp[5:0]}, 1'b1);
            runs_by_len[2]++;
        end
        else begin
            expect_beat({4'b1110, cp[15:12]}, 1'b0);
            expect_beat({2'b10, cp[11:6]}, 1'b0);
            expect_beat({2'b10, cp[5:0]}, 1'b1);
            runs_by_len[3]++;
        end
    endfunction

    function automatic void flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] mismatch: %s", $realtime, what);
    endfunction

    // text byte sender
    always @(posedge clk)
    begin : text_driver
        logic       next_valid;
        logic [7:0] next_byte;
        next_valid = in_valid;
        next_byte  = text_byte;
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                predict_run(text_byte);
                bytes_sent++;
                next_valid = 1'b0;
            end
            if (!next_valid && text_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_valid = 1'b1;
                next_byte  = text_q.pop_front();
            end
        end
        in_valid  <= next_valid;
        text_byte <= next_byte;
    end

    // UTF-8 beat receiver and checker
    always @(posedge clk)
    begin : utf8_monitor
        utf8_beat_t want;
        if (rst_n && out_valid && !out_stall) begin
            beats_checked++;
            if (utf8_exp_q.size() == 0) begin
                flag_mismatch($sformatf("beat %02h last %0b with no run pending",
                                        utf8_byte, run_last));
            end
            else begin
                want = utf8_exp_q.pop_front();
                if (utf8_byte !== want.octet)
                    flag_mismatch($sformatf("utf8_byte expected %02h, got %02h",
                                            want.octet, utf8_byte));
                if (run_last !== want.last)
                    flag_mismatch($sformatf("run_last expected %0b, got %0b on beat %02h",
                                            want.last, run_last, utf8_byte));
            end
        end
        out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
    end

    task automatic wait_idle();
        do
            @(negedge clk);
        while (text_q.size() != 0 || in_valid || utf8_exp_q.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_charset(input logic [2:0] cs);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CHARSET_ADDR;
        pwdata  <= CFG_DATA_W'(cs);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        src_mode = cs;
        settings_used++;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== CFG_DATA_W'(cs))
            flag_mismatch($sformatf("source_charset read %0h after writing %0d", prdata, cs));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic queue_bytes(input logic [7:0] bytes [$]);
        foreach (bytes[i])
            text_q.push_back(bytes[i]);
    endtask

    function automatic logic [7:0] random_text_byte();
        // lean on the upper half, where the tables live
        if ($urandom_range(99) < 70)
            return 8'(8'h80 + $urandom_range(127));
        return 8'($urandom_range(255));
    endfunction

    initial
    begin : stimulus
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // passthrough straight out of reset, including NUL and the top half
        queue_bytes('{8'h00, 8'h7F, 8'h80, 8'hFF, 8'h55, 8'hAA});
        wait_idle();
        set_charset(CS_LATIN1);
        queue_bytes('{8'h00, 8'h80, 8'hFF});
        wait_idle();
        set_charset(CS_ISO2);
        queue_bytes('{8'hA1, 8'hFF});
        wait_idle();
        // euro sign and an undefined code unit
        set_charset(CS_W1250);
        queue_bytes('{8'h80, 8'h81});
        wait_idle();
        set_charset(CS_W1252);
        queue_bytes('{8'h9F, 8'h8D});
        wait_idle();
        set_charset(CS_CP852);
        queue_bytes('{8'hB0, 8'hFF});
        wait_idle();
        set_charset(CS_SPARE_6);
        queue_bytes('{8'hE9});
        wait_idle();
        set_charset(CS_SPARE_7);
        queue_bytes('{8'h41, 8'hC8});
        wait_idle();

        foreach (PHASE_CHARSETS[p]) begin
            set_charset(PHASE_CHARSETS[p]);
            send_idle_pct  = (p == 4) ? 0 : 15;
            recv_stall_pct = (p == 4) ? 0 : 15;
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                // hold the sender until the block has fully drained
                if (p == 2 && i == ITEMS_PER_PHASE / 2)
                    wait_idle();
                text_q.push_back(random_text_byte());
            end
            wait_idle();
        end

        repeat (10) @(posedge clk);
        $display("Sent %0d text bytes over %0d charset writes; checked %0d UTF-8 beats.",
                 bytes_sent, settings_used, beats_checked);
        $display("Runs of length 1/2/3: %0d/%0d/%0d, mismatches: %0d",
                 runs_by_len[1], runs_by_len[2], runs_by_len[3], mismatches);
        if (mismatches == 0 && utf8_exp_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("Timed out with %0d beats still pending", utf8_exp_q.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
